// File: rtl/pf2d_pkg.sv
// Shared types, constants and controller/datapath interface structs for the Pareto front filter.
package pf2d_pkg;

    localparam int PT_W            = 32;  // one cost component
    localparam int CNT_W           = 7;   // entry count / set size
    localparam int OP_W            = 2;
    localparam int DEF_SET_CAPACITY = 64;
    localparam int MAX_SET_CAPACITY = 64;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // what an outstanding RAM read is for
    typedef enum logic [1:0] {
        RK_SCAN = 2'd0,
        RK_PACK = 2'd1,
        RK_OUT  = 2'd2
    } t_rd_kind;

    typedef struct packed {
        logic     cap;        // latch the input transaction
        logic     start;      // clear result flags
        logic     idx_clr;    // rewind read and write pointers
        logic     rd;         // issue a RAM read at the read pointer
        t_rd_kind rd_kind;
        logic     set_ovf;
        logic     append;     // write the new point at the write pointer
        logic     clr_count;
        logic     resp_load;  // load the single status result
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic cnt_zero;
        logic full;
        logic rd_more;   // read pointer below entry count
        logic rd_ok;     // read data stage can take a new read
        logic pend;      // read data stage holds an entry
        logic dom;
        logic rem;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/pareto_front_2d_filter_unit.sv
// Top level of the bounded two-cost Pareto front filter.
// One operation per input transaction on s_axis: opcode in s_axis_tuser (check,
// insert, readout, clear), the point (time, length) in s_axis_tdata. Results
// leave on m_axis: one status transaction for check, insert and clear, one per
// stored entry for readout (tuser marks a carried entry, tlast the final one),
// a single empty one if the set is empty.
// Sequence per operation, N stored entries: check reads the N entries from
// the RAM one a cycle, drains the read stage, leaves the scan, decides, loads
// the response and returns to idle; on an empty set it skips the scan. Insert
// runs the scan, an in-place compaction pass over the same RAM and the append;
// a refused insert takes as long as a check. Clear goes straight to the response.
// Readout streams the entries one a cycle while the receiver does not stall, a
// rate set by the single read port of the point store. One operation in
// flight: s_axis_tready is high while the sequencer is idle, even while the
// last result still waits in the output register.
// Reset (synchronous, active low) empties the set and drops any pending
// result; stored points are not cleared since entries past the count are
// never read. When the receiver stalls, the output register holds its
// transaction and readout pauses with one entry parked in the RAM read stage.
module pareto_front_2d_filter_unit #(
    parameter int SET_CAPACITY = pf2d_pkg::DEF_SET_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] point_time, [63:32] point_length
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [0] dominated, [1] inserted, [2] overflow,
                                        // [9:3] set_size, [41:10] entry_time,
                                        // [73:42] entry_length, [79:74] zero
    output logic        m_axis_tuser,   // [0] entry_valid
    output logic        m_axis_tlast    // last
);

    localparam int PT_W  = pf2d_pkg::PT_W;
    localparam int CNT_W = pf2d_pkg::CNT_W;

    pf2d_pkg::t_cmd w_cmd;
    pf2d_pkg::t_sts w_sts;
    pf2d_pkg::t_op  w_in_op;

    logic              w_dom;
    logic              w_ins;
    logic              w_ovf;
    logic [CNT_W-1:0]  w_size;
    logic [PT_W-1:0]   w_et;
    logic [PT_W-1:0]   w_el;

    assign w_in_op = pf2d_pkg::t_op'(s_axis_tuser);

    pf2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (w_in_op),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    pf2d_dp #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_in_op        (w_in_op),
        .i_in_time      (s_axis_tdata[PT_W-1:0]),
        .i_in_length    (s_axis_tdata[2*PT_W-1:PT_W]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_dominated    (w_dom),
        .o_inserted     (w_ins),
        .o_overflow     (w_ovf),
        .o_set_size     (w_size),
        .o_entry_valid  (m_axis_tuser),
        .o_entry_time   (w_et),
        .o_entry_length (w_el),
        .o_last         (m_axis_tlast)
    );

    // pack result fields, first field in the low bits
    assign m_axis_tdata = {6'b0, w_el, w_et, w_size, w_ovf, w_ins, w_dom};

    // the set never reports more entries than it can hold
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9:3] <= CNT_W'(SET_CAPACITY)))
        else $error("set_size exceeds capacity");

    // at most one of dominated / inserted / overflow per result
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
        else $error("conflicting status flags");

    // only readout produces multi-transaction results
    a_nonlast_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
        else $error("non-final result without an entry");

    // one operation in flight: the cycle after an accept the input is closed
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an operation is in progress");

endmodule

// File: rtl/pf2d_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module pf2d_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pf2d_ctrl.sv
// Operation sequencer: scan, compaction, append, readout and response control.
module pf2d_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pf2d_pkg::t_op i_in_op,
    input  pf2d_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output pf2d_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PACK,
        S_APPEND,
        S_READ,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.rd_kind     = pf2d_pkg::RK_SCAN;
        o_in_ready        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap     = 1'b1;
                    o_cmd.start   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    unique case (i_in_op)
                        pf2d_pkg::OP_CHECK,
                        pf2d_pkg::OP_INSERT: begin
                            n_state = i_sts.cnt_zero ? S_DECIDE : S_SCAN;
                        end
                        pf2d_pkg::OP_READ: begin
                            n_state = i_sts.cnt_zero ? S_RESP : S_READ;
                        end
                        pf2d_pkg::OP_CLEAR: begin
                            o_cmd.clr_count = 1'b1;
                            n_state         = S_RESP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.rd_more) begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_kind = pf2d_pkg::RK_SCAN;
                end else if (!i_sts.pend) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_sts.op == pf2d_pkg::OP_CHECK || i_sts.dom) begin
                    n_state = S_RESP;
                end else if (!i_sts.rem && i_sts.full) begin
                    o_cmd.set_ovf = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_PACK;
                end
            end
            S_PACK: begin
                if (i_sts.rd_more) begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_kind = pf2d_pkg::RK_PACK;
                end else if (!i_sts.pend) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_RESP;
            end
            S_READ: begin
                if (i_sts.rd_more) begin
                    if (i_sts.rd_ok) begin
                        o_cmd.rd      = 1'b1;
                        o_cmd.rd_kind = pf2d_pkg::RK_OUT;
                    end
                end else if (!i_sts.pend) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: rtl/pf2d_dp.sv
// Datapath: point store, read pipeline, dominance compares, compaction and result register.
module pf2d_dp #(
    parameter int SET_CAPACITY = pf2d_pkg::DEF_SET_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pf2d_pkg::t_cmd              i_cmd,
    output pf2d_pkg::t_sts              o_sts,
    input  pf2d_pkg::t_op               i_in_op,
    input  logic [pf2d_pkg::PT_W-1:0]   i_in_time,
    input  logic [pf2d_pkg::PT_W-1:0]   i_in_length,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_dominated,
    output logic                        o_inserted,
    output logic                        o_overflow,
    output logic [pf2d_pkg::CNT_W-1:0]  o_set_size,
    output logic                        o_entry_valid,
    output logic [pf2d_pkg::PT_W-1:0]   o_entry_time,
    output logic [pf2d_pkg::PT_W-1:0]   o_entry_length,
    output logic                        o_last
);

    localparam int AW    = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int PT_W  = pf2d_pkg::PT_W;
    localparam int CNT_W = pf2d_pkg::CNT_W;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(SET_CAPACITY);

    pf2d_pkg::t_op      r_op;
    logic [PT_W-1:0]    r_pt_t;
    logic [PT_W-1:0]    r_pt_l;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_k;
    logic               r_dom;
    logic               r_rem;
    logic               r_ins;
    logic               r_ovf;
    logic               r_rv;
    pf2d_pkg::t_rd_kind r_rk;
    logic               r_rlast;

    logic               r_o_valid;
    logic               r_o_dom;
    logic               r_o_ins;
    logic               r_o_ovf;
    logic [CNT_W-1:0]   r_o_size;
    logic               r_o_ev;
    logic [PT_W-1:0]    r_o_t;
    logic [PT_W-1:0]    r_o_l;
    logic               r_o_last;

    logic [2*PT_W-1:0]  w_rdata;
    logic [PT_W-1:0]    w_rt;
    logic [PT_W-1:0]    w_rl;
    logic               w_out_free;
    logic               w_consume;
    logic               w_cov_old;
    logic               w_cov_new;
    logic               w_pack_we;
    logic               w_app_we;
    logic               w_we;
    logic [2*PT_W-1:0]  w_wdata;

    pf2d_ram #(
        .WIDTH (2 * PT_W),
        .DEPTH (SET_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_k[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rt       = w_rdata[PT_W-1:0];
    assign w_rl       = w_rdata[2*PT_W-1:PT_W];
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_consume  = r_rv && ((r_rk != pf2d_pkg::RK_OUT) || w_out_free);
    // stored point weakly dominates the new one, and the reverse
    assign w_cov_old  = (w_rt <= r_pt_t) && (w_rl <= r_pt_l);
    assign w_cov_new  = (r_pt_t <= w_rt) && (r_pt_l <= w_rl);
    assign w_pack_we  = w_consume && (r_rk == pf2d_pkg::RK_PACK) && !w_cov_new;
    assign w_app_we   = i_cmd.append && (r_k < CAP);
    assign w_we       = w_pack_we || w_app_we;
    assign w_wdata    = w_pack_we ? w_rdata : {r_pt_l, r_pt_t};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv      <= 1'b0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_rv <= 1'b1;
            end else if (w_consume) begin
                r_rv <= 1'b0;
            end
            if (i_cmd.clr_count) begin
                r_cnt <= '0;
            end else if (i_cmd.append) begin
                r_cnt <= w_app_we ? r_k + CNT_W'(1) : r_k;
            end
            if (i_cmd.resp_load || (w_consume && r_rk == pf2d_pkg::RK_OUT)) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op   <= i_in_op;
            r_pt_t <= i_in_time;
            r_pt_l <= i_in_length;
        end
        if (i_cmd.rd) begin
            r_rk    <= i_cmd.rd_kind;
            r_rlast <= (r_idx == r_cnt - CNT_W'(1));
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
            r_k   <= '0;
        end else begin
            if (i_cmd.rd) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (w_pack_we) begin
                r_k <= r_k + CNT_W'(1);
            end
        end
        if (i_cmd.start) begin
            r_dom <= 1'b0;
            r_rem <= 1'b0;
            r_ins <= 1'b0;
            r_ovf <= 1'b0;
        end else begin
            if (w_consume && r_rk == pf2d_pkg::RK_SCAN) begin
                r_dom <= r_dom | w_cov_old;
                r_rem <= r_rem | w_cov_new;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.append) begin
                r_ins <= 1'b1;
            end
        end
        // result register
        if (i_cmd.resp_load) begin
            r_o_dom  <= r_dom;
            r_o_ins  <= r_ins;
            r_o_ovf  <= r_ovf;
            r_o_size <= r_cnt;
            r_o_ev   <= 1'b0;
            r_o_t    <= '0;
            r_o_l    <= '0;
            r_o_last <= 1'b1;
        end else if (w_consume && r_rk == pf2d_pkg::RK_OUT) begin
            r_o_dom  <= 1'b0;
            r_o_ins  <= 1'b0;
            r_o_ovf  <= 1'b0;
            r_o_size <= r_cnt;
            r_o_ev   <= 1'b1;
            r_o_t    <= w_rt;
            r_o_l    <= w_rl;
            r_o_last <= r_rlast;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.op       = r_op;
        o_sts.cnt_zero = (r_cnt == '0);
        o_sts.full     = (r_cnt >= CAP);
        o_sts.rd_more  = (r_idx < r_cnt);
        o_sts.rd_ok    = !r_rv || w_consume;
        o_sts.pend     = r_rv;
        o_sts.dom      = r_dom;
        o_sts.rem      = r_rem;
        o_sts.out_free = w_out_free;
    end

    assign o_out_valid    = r_o_valid;
    assign o_dominated    = r_o_dom;
    assign o_inserted     = r_o_ins;
    assign o_overflow     = r_o_ovf;
    assign o_set_size     = r_o_size;
    assign o_entry_valid  = r_o_ev;
    assign o_entry_time   = r_o_t;
    assign o_entry_length = r_o_l;
    assign o_last         = r_o_last;

endmodule

// File: sim/pf2d_front_checker.sv
// Checker for the Pareto front filter: watches both channels, predicts the front and compares.
module pf2d_front_checker
    import pf2d_pkg::*;
#(
    parameter int SET_CAPACITY = DEF_SET_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] point_time, [63:32] point_length
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,   // [0] dominated, [1] inserted, [2] overflow,
                                        // [9:3] set_size, [41:10] entry_time,
                                        // [73:42] entry_length, [79:74] zero
    input  logic        m_axis_tuser,   // [0] entry_valid
    input  logic        m_axis_tlast,
    output int          o_mismatch_count,
    output int          o_pending_results,
    output int          o_results_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        dominated;
        logic        inserted;
        logic        overflow;
        logic [6:0]  set_size;
        logic        entry_valid;
        logic [31:0] entry_time;
        logic [31:0] entry_length;
        logic        is_last;
        logic [5:0]  pad;
    } front_result_t;

    localparam int PRINT_LIMIT = 40;

    // predicted front, in insertion order
    logic [31:0]   front_time   [SET_CAPACITY];
    logic [31:0]   front_length [SET_CAPACITY];
    int            front_count = 0;
    front_result_t front_results_q [$];
    front_result_t seen_result;
    front_result_t want_result;
    int            mismatch_count = 0;
    int            compared_count = 0;

    assign o_mismatch_count   = mismatch_count;
    assign o_results_compared = compared_count;

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] ERROR result %0d: %s", $realtime, compared_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // appends one expected result at the tail of the queue
    task automatic enqueue_result(input front_result_t res);
        front_results_q = {front_results_q, res};
    endtask

    // Applies one operation to the predicted front and queues the results it causes.
    task automatic advance_front(input t_op op, input logic [31:0] pt_time,
                                 input logic [31:0] pt_length);
        front_result_t r;
        logic          covered;
        logic          trims;
        int            kept;
        r       = '0;
        r.is_last = 1'b1;
        covered = 1'b0;
        trims   = 1'b0;
        kept    = 0;
        for (int i = 0; i < front_count; i++) begin
            if (front_time[i] <= pt_time && front_length[i] <= pt_length)
                covered = 1'b1;
            if (pt_time <= front_time[i] && pt_length <= front_length[i])
                trims = 1'b1;
        end
        case (op)
            OP_CHECK: r.dominated = covered;
            OP_INSERT: begin
                if (covered) begin
                    r.dominated = 1'b1;
                end else if (!trims && front_count >= SET_CAPACITY) begin
                    r.overflow = 1'b1;
                end else begin
                    for (int i = 0; i < front_count; i++) begin
                        if (!(pt_time <= front_time[i] && pt_length <= front_length[i])) begin
                            front_time[kept]   = front_time[i];
                            front_length[kept] = front_length[i];
                            kept++;
                        end
                    end
                    front_time[kept]   = pt_time;
                    front_length[kept] = pt_length;
                    front_count        = kept + 1;
                    r.inserted         = 1'b1;
                end
            end
            OP_READ: begin
                for (int i = 0; i < front_count; i++) begin
                    r.entry_valid  = 1'b1;
                    r.entry_time   = front_time[i];
                    r.entry_length = front_length[i];
                    r.set_size     = 7'(front_count);
                    r.is_last      = (i == front_count - 1);
                    enqueue_result(r);
                end
            end
            OP_CLEAR: front_count = 0;
            default: ;
        endcase
        // a non-empty readout has already queued its entries
        if (!(op == OP_READ && front_count > 0)) begin
            r.set_size = 7'(front_count);
            enqueue_result(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // results leaving now stem from earlier transactions, so compare first
            if (m_axis_tvalid && m_axis_tready) begin
                seen_result = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2],
                               m_axis_tdata[9:3], m_axis_tuser, m_axis_tdata[41:10],
                               m_axis_tdata[73:42], m_axis_tlast, m_axis_tdata[79:74]};
                if (front_results_q.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want_result = front_results_q.pop_front();
                    check_field("dominated", seen_result.dominated, want_result.dominated);
                    check_field("inserted", seen_result.inserted, want_result.inserted);
                    check_field("overflow", seen_result.overflow, want_result.overflow);
                    check_field("set_size", seen_result.set_size, want_result.set_size);
                    check_field("entry_valid", seen_result.entry_valid,
                                want_result.entry_valid);
                    check_field("entry_time", seen_result.entry_time, want_result.entry_time);
                    check_field("entry_length", seen_result.entry_length,
                                want_result.entry_length);
                    check_field("tlast", seen_result.is_last, want_result.is_last);
                    check_field("tdata padding", seen_result.pad, want_result.pad);
                end
                compared_count++;
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_front(t_op'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32]);
        end
        o_pending_results <= front_results_q.size();
    end

endmodule

// File: sim/testbench.sv
// Top of the Pareto front filter testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pf2d_pkg::*;

    localparam int CAPACITY    = DEF_SET_CAPACITY;
    localparam int CYCLE_LIMIT = 500_000;   // slowest legal run stays far below this
    localparam int DRAIN_WAIT  = 200;       // longer than an insert into a full front

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;       // [31:0] point_time, [63:32] point_length
    logic [1:0]  s_axis_tuser  = OP_CHECK; // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;             // [0] dominated, [1] inserted, [2] overflow,
                                           // [9:3] set_size, [41:10] entry_time,
                                           // [73:42] entry_length, [79:74] zero
    logic        m_axis_tuser;             // [0] entry_valid
    logic        m_axis_tlast;

    int mismatch_count;
    int pending_results;
    int results_compared;

    // idle rates in percent, per side
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int cycle_count   = 0;
    int ops_sent [4]  = '{default: 0};

    // staircase points: time rises, length falls, so none covers another
    logic [31:0] stair_time   [CAPACITY];
    logic [31:0] stair_length [CAPACITY];

    always #4 i_clk = ~i_clk;

    pareto_front_2d_filter_unit #(
        .SET_CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    pf2d_front_checker #(
        .SET_CAPACITY(CAPACITY)
    ) i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tuser       (s_axis_tuser),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tuser       (m_axis_tuser),
        .m_axis_tlast       (m_axis_tlast),
        .o_mismatch_count   (mismatch_count),
        .o_pending_results  (pending_results),
        .o_results_compared (results_compared)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // Watchdog: a hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one transaction, with random idle cycles ahead of it, and returns at the
    // edge that accepts it. Only one assignment to tvalid happens per edge.
    task automatic put_op(input t_op op, input logic [31:0] pt_time,
                          input logic [31:0] pt_length);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {pt_length, pt_time};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        ops_sent[op]++;
    endtask

    // Drops tvalid and holds until every predicted result has been received.
    // The checker's pending count is registered, so the loop waits on the clock before its first look.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results != 0);
    endtask

    task automatic set_idle(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    // Coordinates clustered near zero or near the top of the range, so that
    // inserts collide often; now and then a fully random one.
    function automatic logic [31:0] pick_coord();
        logic [31:0] base;
        base = $urandom_range(0, 1) ? 32'hFFFF_FFE0 : 32'h0;
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        return base + 32'($urandom_range(0, 31));
    endfunction

    task automatic random_operation();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            put_op(OP_INSERT, pick_coord(), pick_coord());
        else if (roll < 70)
            put_op(OP_CHECK, pick_coord(), pick_coord());
        else if (roll < 84)
            put_op(OP_READ, pick_coord(), pick_coord());
        else if (roll < 89)
            put_op(OP_CLEAR, pick_coord(), pick_coord());
        else
            put_op(t_op'($urandom_range(0, 3)), $urandom(), $urandom());
    endtask

    // Fills the front to capacity with a shuffled staircase, then drives the
    // full-set cases: refused insert, insert that replaces one entry, full readout.
    task automatic fill_to_capacity();
        logic [31:0] t_step;
        logic [31:0] l_step;
        logic [31:0] t_base;
        logic [31:0] l_top;
        int          order [CAPACITY];
        int          j;
        int          tmp;
        int          k;
        t_step = $urandom_range(1, 60_000_000);
        l_step = $urandom_range(2, 60_000_000);
        t_base = $urandom_range(0, 400_000_000);
        l_top  = 32'hFFFF_FFFF - $urandom_range(0, 400_000_000);
        for (int i = 0; i < CAPACITY; i++) begin
            stair_time[i]   = t_base + i * t_step;
            stair_length[i] = l_top - i * l_step;
            order[i]        = i;
        end
        for (int i = CAPACITY - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        put_op(OP_CLEAR, 32'h0, 32'h0);
        for (int i = 0; i < CAPACITY; i++)
            put_op(OP_INSERT, stair_time[order[i]], stair_length[order[i]]);
        // right of and below every entry: neither covered nor covering -> overflow
        put_op(OP_INSERT, stair_time[CAPACITY-1] + 1, stair_length[CAPACITY-1] - 1);
        put_op(OP_CHECK, stair_time[CAPACITY-1] + 1, stair_length[CAPACITY-1] - 1);
        put_op(OP_CHECK, stair_time[3], stair_length[3]);
        put_op(OP_READ, $urandom(), $urandom());
        // covers exactly entry k, so the full front trades it for the new point
        k = $urandom_range(0, CAPACITY - 2);
        put_op(OP_INSERT, stair_time[k], stair_length[k] - 1);
        put_op(OP_INSERT, stair_time[CAPACITY-1] + 1, stair_length[CAPACITY-1] - 1);
        put_op(OP_READ, $urandom(), $urandom());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase A: sender idles lightly, receiver heavily.
        set_idle(20, 58);

        // directed cases on an empty, then a tiny front
        put_op(OP_READ, 32'h0, 32'h0);                       // empty readout
        put_op(OP_CHECK, 32'h0, 32'h0);                      // nothing stored
        put_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);     // equal point is refused
        put_op(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_op(OP_CHECK, 32'hFFFF_FFFE, 32'hFFFF_FFFF);      // better in time only
        put_op(OP_INSERT, 32'h0, 32'hFFFF_FFFF);             // displaces the corner point
        put_op(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        put_op(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_op(OP_CHECK, 32'h0, 32'h0);
        put_op(OP_INSERT, 32'h0, 32'h0);                     // removes both entries
        put_op(OP_INSERT, 32'h0, 32'h0);
        put_op(OP_INSERT, 32'h5, 32'h5);
        put_op(OP_READ, 32'h0, 32'h0);
        put_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_op(OP_CLEAR, 32'h0, 32'h0);                      // clear when already empty
        put_op(OP_READ, 32'h0, 32'h0);
        put_op(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        put_op(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        put_op(OP_CHECK, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        put_op(OP_CHECK, 32'h5555_5554, 32'hFFFF_FFFF);
        put_op(OP_READ, 32'h0, 32'h0);
        put_op(OP_CLEAR, 32'h0, 32'h0);

        // let the output side run dry once before the random traffic
        hold_until_drained();
        for (int n = 0; n < 40; n++)
            random_operation();

        // Phase B: roles swapped.
        set_idle(58, 20);
        fill_to_capacity();
        for (int n = 0; n < 45; n++)
            random_operation();

        // Phase C: both sides at full rate.
        set_idle(0, 0);
        for (int n = 0; n < 45; n++)
            random_operation();

        hold_until_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d transactions: %0d check, %0d insert, %0d readout, %0d clear",
                 ops_sent[OP_CHECK] + ops_sent[OP_INSERT] + ops_sent[OP_READ]
                 + ops_sent[OP_CLEAR], ops_sent[OP_CHECK], ops_sent[OP_INSERT],
                 ops_sent[OP_READ], ops_sent[OP_CLEAR]);
        $display("Compared %0d result transactions, front filled to %0d with overflow",
                 results_compared, CAPACITY);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
